>>> rtl/core/rcpc_pkg.sv
// Shared types and constants for the RC pulse capture block.
// No dependencies; every other file in rtl/core imports this package.
package rcpc_pkg;

  // Channel count and the pin mask that follows from it
  localparam int unsigned NUM_CHANNELS = 8;
  localparam int unsigned CH_SLOTS     = 8;
  localparam logic [7:0]  CHAN_MASK    = 8'(((9'd1 << NUM_CHANNELS) - 9'd1));

  // Full-scale position
  localparam logic [7:0] POS_FULL = 8'd180;

  // Read queue between capture front and evaluation back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // Request codes
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] CFG_TIMEOUT     = 3'd0;
  localparam logic [2:0] CFG_INVALID_LIM = 3'd1;
  localparam logic [2:0] CFG_WIDTH_ZERO  = 3'd2;
  localparam logic [2:0] CFG_WIDTH_FULL  = 3'd3;
  localparam logic [2:0] CFG_DEFAULT_POS = 3'd4;

  typedef struct packed {
    logic       req_type;
    logic [7:0] pin_levels;
    logic [2:0] channel;
  } req_item_t;

  typedef struct packed {
    logic [2:0]  channel_out;
    logic [15:0] pulse_width_us;
    logic [7:0]  position;
    logic        signal_present;
  } rsp_item_t;

  typedef struct packed {
    logic [15:0] timeout_us;
    logic [15:0] invalid_limit_us;
    logic [15:0] width_at_zero_us;
    logic [15:0] width_at_full_us;
    logic [7:0]  default_position;
  } cfg_t;

  // Snapshot of one channel taken when its read is accepted
  typedef struct packed {
    logic [2:0]  channel;
    logic [31:0] age;
    logic [15:0] width;
  } rd_entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_EVAL,
    BK_MUL,
    BK_DIV,
    BK_EMIT
  } back_state_t;

endpackage

>>> rtl/core/rcpc_front.sv
// Capture front: tracks time and edges per channel, snapshots channels for reads.
// Depends on rcpc_pkg.
module rcpc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  rcpc_pkg::req_item_t req,
  input  logic               q_full,
  output logic               req_stall,
  output logic               push,
  output rcpc_pkg::rd_entry_t push_entry
);
  import rcpc_pkg::*;

  logic [31:0] time_now;
  logic [7:0]  prev_levels;
  logic [31:0] rise_time [CH_SLOTS];
  logic [15:0] high_width [CH_SLOTS];

  logic       tick;
  logic [7:0] levels;
  logic       ch_ok;

  // Ticks never wait; a read waits only for queue space
  assign req_stall = (req.req_type == REQ_READ) && q_full;
  assign tick      = req_valid && !req_stall && (req.req_type == REQ_TICK);
  assign push      = req_valid && !req_stall && (req.req_type == REQ_READ);
  assign levels    = req.pin_levels & CHAN_MASK;
  assign ch_ok     = {1'b0, req.channel} < 4'(NUM_CHANNELS);

  // Snapshot age and width of the requested channel
  always_comb begin
    push_entry.channel = req.channel;
    push_entry.age     = time_now - rise_time[req.channel];
    push_entry.width   = ch_ok ? high_width[req.channel] : 16'd0;
  end

  // Advance time and record edges on each tick
  always_ff @(posedge clk) begin
    if (rst) begin
      time_now    <= '0;
      prev_levels <= '0;
      for (int i = 0; i < CH_SLOTS; i++) begin
        rise_time[i]  <= '0;
        high_width[i] <= '0;
      end
    end else if (tick) begin
      for (int i = 0; i < CH_SLOTS; i++) begin
        logic [31:0] hi_time;
        hi_time = time_now - rise_time[i];
        if (levels[i] && !prev_levels[i]) begin
          rise_time[i] <= time_now;
        end else if (!levels[i] && prev_levels[i]) begin
          high_width[i] <= (|hi_time[31:16]) ? 16'hFFFF : hi_time[15:0];
        end
      end
      prev_levels <= levels;
      time_now    <= time_now + 32'd1;
    end
  end

endmodule

>>> rtl/core/rcpc_queue.sv
// Small FIFO of read snapshots between the capture front and the evaluation back.
// Depends on rcpc_pkg.
module rcpc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rcpc_pkg::rd_entry_t push_entry,
  input  logic                pop,
  output rcpc_pkg::rd_entry_t head,
  output logic                empty,
  output logic                full
);
  import rcpc_pkg::*;

  rd_entry_t        slots [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     count;

  assign empty = (count == '0);
  assign full  = (count == (QAW+1)'(QDEPTH));
  assign head  = slots[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/rcpc_back.sv
// Evaluation back: validates a snapshot, maps width to position, holds the result.
// Depends on rcpc_pkg; uses an 8-step restoring divider for the mapping.
module rcpc_back (
  input  logic                clk,
  input  logic                rst,
  input  rcpc_pkg::cfg_t      cfg,
  input  rcpc_pkg::rd_entry_t head,
  input  logic                q_empty,
  output logic                pop,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output rcpc_pkg::rsp_item_t rsp
);
  import rcpc_pkg::*;

  back_state_t state;
  back_state_t state_next;

  rd_entry_t   ent;
  rsp_item_t   res;
  logic [15:0] diff;
  logic [15:0] den;
  logic [23:0] rem;
  logic [23:0] den_sh;
  logic [7:0]  quot;
  logic [2:0]  div_cnt;

  logic        ok;
  logic        degen;
  logic        at_low;
  logic        at_high;
  logic        direct;
  logic        load;
  logic        slot_free;
  logic [24:0] trial;

  // Classify the current snapshot
  always_comb begin
    ok      = (ent.age < {16'd0, cfg.timeout_us}) && (ent.width != 16'd0)
              && (ent.width <= cfg.invalid_limit_us);
    degen   = cfg.width_at_full_us <= cfg.width_at_zero_us;
    at_low  = ent.width <= cfg.width_at_zero_us;
    at_high = ent.width >= cfg.width_at_full_us;
    direct  = !ok || degen || at_low || at_high;
    trial   = {1'b0, rem} - {1'b0, den_sh};
  end

  assign slot_free = !rsp_valid || !rsp_stall;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (!q_empty) state_next = BK_EVAL;
      BK_EVAL: state_next = direct ? BK_EMIT : BK_MUL;
      BK_MUL:  state_next = BK_DIV;
      BK_DIV:  if (div_cnt == 3'd0) state_next = BK_EMIT;
      BK_EMIT: if (slot_free) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop  = 1'b0;
    load = 1'b0;
    unique case (state)
      BK_IDLE: pop  = !q_empty;
      BK_EMIT: load = slot_free;
      default: begin
        pop  = 1'b0;
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: capture, classify, multiply, divide
  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        if (pop) begin
          ent <= head;
        end
      end
      BK_EVAL: begin
        res.channel_out    <= ent.channel;
        res.pulse_width_us <= ok ? ent.width : 16'd0;
        res.signal_present <= ok;
        if (!ok) begin
          res.position <= cfg.default_position;
        end else if (degen || at_low) begin
          res.position <= 8'd0;
        end else begin
          res.position <= POS_FULL;
        end
        diff <= ent.width - cfg.width_at_zero_us;
        den  <= cfg.width_at_full_us - cfg.width_at_zero_us;
      end
      BK_MUL: begin
        rem     <= 24'(diff) * 24'(POS_FULL);
        den_sh  <= {1'b0, den, 7'd0};
        quot    <= '0;
        div_cnt <= 3'd7;
      end
      BK_DIV: begin
        if (!trial[24]) begin
          rem  <= trial[23:0];
          quot <= {quot[6:0], 1'b1};
        end else begin
          quot <= {quot[6:0], 1'b0};
        end
        den_sh  <= den_sh >> 1;
        div_cnt <= div_cnt - 3'd1;
        if (div_cnt == 3'd0) begin
          res.position <= {quot[6:0], !trial[24]};
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= res;
    end
  end

endmodule

>>> rtl/core/rc_pulse_capture_to_position.sv
// Ticks are absorbed one per cycle and never stall; reads snapshot their channel on accept.
// An accepted read is queued, popped in the back's IDLE state and evaluated in EVAL; if the
// width is mapped it then passes MUL and the 8-step divider (DIV), and EMIT registers the
// result. The back works one read at a time; a 4-entry queue accepts reads until full.
// Synchronous reset loads the default registers and zeroes time, edge and width state.
// Depends on rcpc_pkg, rcpc_front, rcpc_queue and rcpc_back.
module rc_pulse_capture_to_position (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  rcpc_pkg::req_item_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output rcpc_pkg::rsp_item_t rsp,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import rcpc_pkg::*;

  cfg_t      cfg;
  rd_entry_t push_entry;
  rd_entry_t head;
  logic      push;
  logic      pop;
  logic      q_empty;
  logic      q_full;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_us       <= 16'd25000;
      cfg.invalid_limit_us <= 16'd2500;
      cfg.width_at_zero_us <= 16'd1000;
      cfg.width_at_full_us <= 16'd2000;
      cfg.default_position <= 8'd90;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TIMEOUT:     cfg.timeout_us       <= cfg_data;
        CFG_INVALID_LIM: cfg.invalid_limit_us <= cfg_data;
        CFG_WIDTH_ZERO:  cfg.width_at_zero_us <= cfg_data;
        CFG_WIDTH_FULL:  cfg.width_at_full_us <= cfg_data;
        CFG_DEFAULT_POS: cfg.default_position <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  rcpc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req        (req),
    .q_full     (q_full),
    .req_stall  (req_stall),
    .push       (push),
    .push_entry (push_entry)
  );

  rcpc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  rcpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

>>> rtl/core/rcpc_checker.sv
// Port-level checks for the RC pulse capture top level, attached by bind.
// Depends on rcpc_pkg.
module rcpc_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_stall,
  input rcpc_pkg::req_item_t req,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input rcpc_pkg::rsp_item_t rsp
);
  import rcpc_pkg::*;

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // Ticks are never stalled
  a_tick_free: assert property (@(posedge clk) disable iff (rst)
    req_valid && (req.req_type == REQ_TICK) |-> !req_stall)
    else $error("tick transaction stalled");

  // Absent pulse reports zero width
  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.signal_present |-> rsp.pulse_width_us == 16'd0)
    else $error("absent pulse with nonzero width");

  // Present pulse has a width and an in-range position
  a_present_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.signal_present |->
      (rsp.pulse_width_us != 16'd0) && (rsp.position <= POS_FULL))
    else $error("present pulse out of range");

endmodule

bind rc_pulse_capture_to_position rcpc_checker u_rcpc_checker (.*);
